// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/hksp_pkg.sv
// ---------------------------------------------------------------------------
// hksp_pkg
// types and constants of the hex key string entry parser
// ---------------------------------------------------------------------------
package hksp_pkg;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef enum logic [3:0] {
      PH_START   = 4'd0,
      PH_LEAD    = 4'd1,
      PH_ZERO    = 4'd2,
      PH_X       = 4'd3,
      PH_HEX     = 4'd4,
      PH_POSTHEX = 4'd5,
      PH_EQ      = 4'd6,
      PH_STR     = 4'd7,
      PH_ENDSTR  = 4'd8,
      PH_ESC     = 4'd9,
      PH_OCT     = 4'd10,
      PH_COMMENT = 4'd11,
      PH_HALT    = 4'd12
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_ENTRY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value_char;
      logic [31:0] entry_id;
      logic [15:0] line_number;
      logic        last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic         halted;
      logic [1:0]   count;
      rsp_item_type r1;
      rsp_item_type r0;
   } rsp_pair_type;

   typedef struct packed {
      logic [RSP_CNT_W-1:0] count;
   } fifo_status_type;

endpackage

// File: rtl/hksp_parser.sv
// ---------------------------------------------------------------------------
// hksp_parser
// per-byte line parser: state registers and the results of one request
// ---------------------------------------------------------------------------
module hksp_parser #(
   parameter int VALUE_CAP = 2048,
   parameter int KEY_CAP   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           text_byte,
   input  logic [15:0]          max_lines,
   output hksp_pkg::rsp_pair_type pair
);

   localparam int KLEN_W = $clog2(KEY_CAP);
   localparam int VLEN_W = $clog2(VALUE_CAP);
   localparam logic [KLEN_W-1:0] KLEN_MAX = KLEN_W'(KEY_CAP - 1);
   localparam logic [VLEN_W-1:0] VLEN_MAX = VLEN_W'(VALUE_CAP - 1);

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;

   hksp_pkg::phase_type  phase_ff, phase_in;
   logic [15:0]          line_ff, line_in;
   logic [31:0]          id_ff, id_in;
   logic [KLEN_W-1:0]    klen_ff, klen_in;
   logic [VLEN_W-1:0]    vlen_ff, vlen_in;
   logic [8:0]           oct_ff, oct_in;
   logic [1:0]           ocnt_ff, ocnt_in;

   logic [7:0]  c;
   logic        is_hex, is_blank, is_space, is_oct;
   logic [3:0]  hex_val;
   logic [15:0] line_sat;

   assign c = text_byte;

   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
   end

   assign is_blank = (c == CH_SPACE) || (c == CH_TAB);
   assign is_space = (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   assign is_oct   = (c >= CH_ZERO) && (c <= CH_SEVEN);
   assign line_sat = (line_ff != 16'hFFFF) ? line_ff + 16'd1 : line_ff;

   always_comb begin
      logic              err, entry, clear_line;
      logic              cha_v, chb_v;
      logic [7:0]        cha, chb;
      logic [VLEN_W-1:0] vl;
      logic [1:0]        n;
      hksp_pkg::rsp_item_type r0, r1, it;

      phase_in   = phase_ff;
      line_in    = line_ff;
      id_in      = id_ff;
      klen_in    = klen_ff;
      oct_in     = oct_ff;
      ocnt_in    = ocnt_ff;
      err        = 1'b0;
      entry      = 1'b0;
      clear_line = 1'b0;
      cha_v      = 1'b0;
      chb_v      = 1'b0;
      cha        = 8'd0;
      chb        = 8'd0;

      if (accept) begin
         unique case (phase_ff)
            hksp_pkg::PH_START, hksp_pkg::PH_LEAD: begin
               if (phase_ff == hksp_pkg::PH_START) begin
                  line_in = line_sat;
                  if (line_sat >= max_lines) begin
                     err = 1'b1;
                  end
               end
               if (!err) begin
                  if (c == CH_NL) begin
                     phase_in = hksp_pkg::PH_START;
                  end else if (is_space) begin
                     phase_in = hksp_pkg::PH_LEAD;
                  end else if (c == CH_HASH) begin
                     phase_in = hksp_pkg::PH_COMMENT;
                  end else if (c == CH_ZERO) begin
                     if (klen_ff < KLEN_MAX) klen_in = klen_ff + 1'b1;
                     phase_in = hksp_pkg::PH_ZERO;
                  end else begin
                     err = 1'b1;
                  end
               end
            end
            hksp_pkg::PH_ZERO: begin
               if (c == 8'h78 || c == 8'h58) begin
                  if (klen_ff < KLEN_MAX) klen_in = klen_ff + 1'b1;
                  phase_in = hksp_pkg::PH_X;
               end else begin
                  err = 1'b1;
               end
            end
            hksp_pkg::PH_X, hksp_pkg::PH_HEX: begin
               if (is_hex) begin
                  if (klen_ff < KLEN_MAX) begin
                     klen_in = klen_ff + 1'b1;
                     id_in   = {id_ff[27:0], hex_val};
                  end
                  phase_in = hksp_pkg::PH_HEX;
               end else if (phase_ff == hksp_pkg::PH_HEX && is_blank) begin
                  phase_in = hksp_pkg::PH_POSTHEX;
               end else if (phase_ff == hksp_pkg::PH_HEX && c == CH_EQ) begin
                  phase_in = hksp_pkg::PH_EQ;
               end else begin
                  err = 1'b1;
               end
            end
            hksp_pkg::PH_POSTHEX: begin
               if (c == CH_EQ) begin
                  phase_in = hksp_pkg::PH_EQ;
               end else if (!is_blank) begin
                  err = 1'b1;
               end
            end
            hksp_pkg::PH_EQ: begin
               if (c == CH_QUOTE) begin
                  phase_in = hksp_pkg::PH_STR;
               end else if (!is_blank) begin
                  err = 1'b1;
               end
            end
            hksp_pkg::PH_STR: begin
               if (c == CH_QUOTE) begin
                  phase_in = hksp_pkg::PH_ENDSTR;
               end else if (c == CH_BSL) begin
                  phase_in = hksp_pkg::PH_ESC;
               end else if (c == CH_NL) begin
                  err = 1'b1;
               end else begin
                  chb_v = 1'b1;
                  chb   = c;
               end
            end
            hksp_pkg::PH_ENDSTR: begin
               if (c == CH_NL) begin
                  entry      = 1'b1;
                  clear_line = 1'b1;
               end else if (c == CH_QUOTE) begin
                  phase_in = hksp_pkg::PH_STR;
               end else if (!is_blank) begin
                  err = 1'b1;
               end
            end
            hksp_pkg::PH_ESC: begin
               if (is_oct) begin
                  oct_in   = {6'd0, c[2:0]};
                  ocnt_in  = 2'd1;
                  phase_in = hksp_pkg::PH_OCT;
               end else begin
                  chb_v = 1'b1;
                  case (c)
                     8'h74:   chb = 8'h09;
                     8'h6E:   chb = 8'h0A;
                     8'h62:   chb = 8'h08;
                     8'h72:   chb = 8'h0D;
                     default: chb = c;
                  endcase
                  phase_in = hksp_pkg::PH_STR;
               end
            end
            hksp_pkg::PH_OCT: begin
               if (ocnt_ff < 2'd3 && is_oct) begin
                  oct_in  = {oct_ff[5:0], c[2:0]};
                  ocnt_in = ocnt_ff + 2'd1;
               end else begin
                  cha_v    = 1'b1;
                  cha      = oct_ff[7:0];
                  oct_in   = 9'd0;
                  ocnt_in  = 2'd0;
                  phase_in = hksp_pkg::PH_STR;
                  if (c == CH_QUOTE) begin
                     phase_in = hksp_pkg::PH_ENDSTR;
                  end else if (c == CH_BSL) begin
                     phase_in = hksp_pkg::PH_ESC;
                  end else if (c == CH_NL) begin
                     err = 1'b1;
                  end else begin
                     chb_v = 1'b1;
                     chb   = c;
                  end
               end
            end
            hksp_pkg::PH_COMMENT: begin
               if (c == CH_NL) phase_in = hksp_pkg::PH_START;
            end
            default: begin
            end
         endcase
      end

      // entry result or value characters in order, each under the value cap
      n  = 2'd0;
      vl = vlen_ff;
      r0 = '0;
      r1 = '0;
      it = '0;
      it.line_number = line_in;
      if (entry) begin
         r0          = it;
         r0.kind     = hksp_pkg::KIND_ENTRY;
         r0.entry_id = id_ff;
         n           = 2'd1;
      end
      if (cha_v && vl < VLEN_MAX) begin
         vl            = vl + 1'b1;
         r0            = it;
         r0.kind       = hksp_pkg::KIND_CHAR;
         r0.value_char = cha;
         n             = 2'd1;
      end
      if (chb_v && vl < VLEN_MAX) begin
         vl = vl + 1'b1;
         if (n == 2'd0) begin
            r0            = it;
            r0.kind       = hksp_pkg::KIND_CHAR;
            r0.value_char = chb;
            n             = 2'd1;
         end else begin
            r1            = it;
            r1.kind       = hksp_pkg::KIND_CHAR;
            r1.value_char = chb;
            n             = 2'd2;
         end
      end
      vlen_in = vl;

      if (clear_line) begin
         id_in    = 32'd0;
         klen_in  = '0;
         vlen_in  = '0;
         oct_in   = 9'd0;
         ocnt_in  = 2'd0;
         phase_in = hksp_pkg::PH_START;
      end

      if (err) begin
         r0       = it;
         r0.kind  = hksp_pkg::KIND_ERROR;
         r1       = '0;
         n        = 2'd1;
         phase_in = hksp_pkg::PH_HALT;
      end

      r0.last_of_run = (n == 2'd1);
      r1.last_of_run = (n == 2'd2);

      pair.halted = (phase_ff != hksp_pkg::PH_START)   && (phase_ff != hksp_pkg::PH_LEAD)
                 && (phase_ff != hksp_pkg::PH_ZERO)    && (phase_ff != hksp_pkg::PH_X)
                 && (phase_ff != hksp_pkg::PH_HEX)     && (phase_ff != hksp_pkg::PH_POSTHEX)
                 && (phase_ff != hksp_pkg::PH_EQ)      && (phase_ff != hksp_pkg::PH_STR)
                 && (phase_ff != hksp_pkg::PH_ENDSTR)  && (phase_ff != hksp_pkg::PH_ESC)
                 && (phase_ff != hksp_pkg::PH_OCT)     && (phase_ff != hksp_pkg::PH_COMMENT);
      pair.count  = n;
      pair.r0     = r0;
      pair.r1     = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hksp_pkg::PH_START;
         line_ff  <= 16'd0;
         id_ff    <= 32'd0;
         klen_ff  <= '0;
         vlen_ff  <= '0;
         oct_ff   <= 9'd0;
         ocnt_ff  <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         id_ff    <= id_in;
         klen_ff  <= klen_in;
         vlen_ff  <= vlen_in;
         oct_ff   <= oct_in;
         ocnt_ff  <= ocnt_in;
      end
   end

endmodule

// File: rtl/hksp_rsp_fifo.sv
// ---------------------------------------------------------------------------
// hksp_rsp_fifo
// result queue: takes up to two results a cycle and, while popped, gives one a cycle
// ---------------------------------------------------------------------------
module hksp_rsp_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  hksp_pkg::rsp_pair_type     pair,
   input  logic                       pop,
   output logic                       out_valid,
   output hksp_pkg::rsp_item_type     out_item,
   output hksp_pkg::fifo_status_type  status
);

   hksp_pkg::rsp_item_type mem [hksp_pkg::RSP_DEPTH];

   logic [hksp_pkg::RSP_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [hksp_pkg::RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           do_pop;

   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem[rd_ff];
   assign do_pop    = pop && out_valid;
   assign wr_next   = wr_ff + 1'b1;

   always_comb begin
      wr_in  = wr_ff + hksp_pkg::RSP_PTR_W'(pair.count);
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + hksp_pkg::RSP_CNT_W'(pair.count)
             - hksp_pkg::RSP_CNT_W'(do_pop);
   end

   assign status.count = cnt_ff;

   always_ff @(posedge clock) begin
      if (pair.count != 2'd0) begin
         mem[wr_ff] <= pair.r0;
      end
      if (pair.count == 2'd2) begin
         mem[wr_next] <= pair.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/hex_key_string_entry_parser.sv
// ---------------------------------------------------------------------------
// hex_key_string_entry_parser
// parses 0xHEX = "value" lines one byte at a time and streams the results
// ---------------------------------------------------------------------------
//  channel  direction  payload
//  req_     in         tdata: text_byte
//  rsp_     out        tdata: value_char, entry_id, line_number; tuser: kind;
//                      tlast: last_of_run
//  csr_     in         data: max_lines
//
//  one byte a cycle, if req_tready; a byte gives zero, one or two results,
//  which the result queue (four entries) hands out one a cycle, if rsp_tready
//  req_tready is high while the queue has room for two results
//  results leave the cycle after the request at the earliest
//  synchronous reset; the parser halts after an error until reset
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_key_string_entry_parser #(
   parameter int VALUE_CAP = 2048,
   parameter int KEY_CAP   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] value_char, [39:8] entry_id, [55:40] line_number
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // [15:0] max_lines
);

   logic [15:0]               max_lines_ff;
   logic                      req_accept;
   hksp_pkg::rsp_pair_type    pair;
   hksp_pkg::rsp_item_type    item;
   hksp_pkg::fifo_status_type fifo_status;

   assign csr_ready  = 1'b1;
   assign req_tready = (fifo_status.count <= hksp_pkg::RSP_CNT_W'(hksp_pkg::RSP_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lines_ff <= 16'd2047;
      end else if (csr_valid && csr_ready) begin
         max_lines_ff <= csr_data;
      end
   end

   hksp_parser #(
      .VALUE_CAP (VALUE_CAP),
      .KEY_CAP   (KEY_CAP)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .text_byte (req_tdata),
      .max_lines (max_lines_ff),
      .pair      (pair)
   );

   hksp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (item),
      .status    (fifo_status)
   );

   assign rsp_tdata = {item.line_number, item.entry_id, item.value_char};
   assign rsp_tuser = item.kind;
   assign rsp_tlast = item.last_of_run;

   `ASSERT_IMPLIES(a_fifo_bound, clock, reset, 1'b1,
      fifo_status.count <= hksp_pkg::RSP_CNT_W'(hksp_pkg::RSP_DEPTH), "result queue overflow")
   `ASSERT_NEXT(a_halt_after_error, clock, reset,
      (pair.count != 2'd0) && (pair.r0.kind == hksp_pkg::KIND_ERROR), pair.halted,
      "parser not halted after error")
   `ASSERT_IMPLIES(a_halted_silent, clock, reset, pair.halted, pair.count == 2'd0,
      "result produced while halted")
   `ASSERT_IMPLIES(a_single_result_kinds, clock, reset,
      rsp_tvalid && (rsp_tuser != hksp_pkg::KIND_CHAR), rsp_tlast,
      "entry or error result without last flag")

endmodule
